// ===== sv/bsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    localparam int TEMP_STAGES  = 4;
    localparam int PRESS_STAGES = 5;
    localparam int STAGES       = TEMP_STAGES + PRESS_STAGES;

    localparam int CFG_IDX_W = 3;
    localparam int COEF_W    = 16;
    localparam int RAW_W     = 24;
    localparam int PRESS_W   = 32;
    localparam int TEMP_W    = 19;

    localparam logic signed [TEMP_W-1:0] T_REF_CENTI = 19'sd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS  = 3'd0,
        REG_OFF   = 3'd1,
        REG_TCS   = 3'd2,
        REG_TCO   = 3'd3,
        REG_TREF  = 3'd4,
        REG_TSENS = 3'd5
    } bsc_reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] tcs;
        logic [COEF_W-1:0] tco;
        logic [COEF_W-1:0] tref;
        logic [COEF_W-1:0] tsens;
    } bsc_cfg_t;

    // hand-off from temperature section to pressure section
    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [37:0]        off;
        logic signed [36:0]        sens;
        logic [34:0]               sq;
        logic                      cold;
        logic signed [TEMP_W-1:0]  temp;
    } bsc_mid_t;

endpackage

`default_nettype wire

// ===== sv/baro_sensor_compensation.sv =====
// Barometric sensor compensation: one raw pressure / raw temperature request in, one
// compensated pressure (0.01 mbar, signed 32 bits) and temperature (0.01 degC, signed
// 19 bits) out, with the second-order correction below 20 degC. A nine-stage pipeline
// takes one request per clock while in_stall is low; its depth is set by the chain of
// 25x17 multiplies, the dT and deviation squares and the 24x37 pressure product split
// over two stages. Each stage holds its data independently, so bubbles collapse and
// in_stall rises only when every stage is full and out_stall is high. Calibration words
// are written through the cfg port (always ready) and must only change while no request
// is in flight.
`timescale 1ns / 1ps
`default_nettype none

module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [RAW_W-1:0]     raw_pressure,
    input  wire logic [RAW_W-1:0]     raw_temperature,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [PRESS_W-1:0] pressure,
    output logic signed [TEMP_W-1:0]  temperature
);

    bsc_cfg_t          cfg;
    bsc_mid_t          mid;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] valid_in;
    logic [STAGES-1:0] en;

    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign valid_in   = {valid_reg[STAGES-2:0], in_valid};
    assign valid_next = (en & valid_in) | (~en & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[STAGES-1];

    bsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bsc_temp_unit u_temp (
        .clk             (clk),
        .en              (en[TEMP_STAGES-1:0]),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .cfg             (cfg),
        .mid             (mid)
    );

    bsc_press_unit u_press (
        .clk         (clk),
        .en          (en[STAGES-1:TEMP_STAGES]),
        .mid         (mid),
        .pressure    (pressure),
        .temperature (temperature)
    );

endmodule

`default_nettype wire

// ===== sv/bsc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsc_cfg_regs
    import bsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]    cfg_data,
    output bsc_cfg_t                  cfg
);

    bsc_cfg_t cfg_reg;
    bsc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SENS:  cfg_next.sens  = cfg_data;
                REG_OFF:   cfg_next.off   = cfg_data;
                REG_TCS:   cfg_next.tcs   = cfg_data;
                REG_TCO:   cfg_next.tco   = cfg_data;
                REG_TREF:  cfg_next.tref  = cfg_data;
                REG_TSENS: cfg_next.tsens = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bsc_temp_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsc_temp_unit
    import bsc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [TEMP_STAGES-1:0] en,
    input  wire logic [RAW_W-1:0]       raw_pressure,
    input  wire logic [RAW_W-1:0]       raw_temperature,
    input  wire bsc_cfg_t               cfg,
    output bsc_mid_t                    mid
);

    // stage 1: dT
    logic signed [24:0] dt_next, dt_reg;
    logic [RAW_W-1:0]   d1_s1_reg;

    // stage 2: dT products
    logic signed [41:0] ts_next, ts_reg;
    logic signed [41:0] tco_next, tco_reg;
    logic signed [41:0] tcs_next, tcs_reg;
    logic signed [49:0] dtsq_next, dtsq_reg;
    logic [RAW_W-1:0]   d1_s2_reg;

    // stage 3: first-order terms
    logic signed [41:0] ts_adj, tco_adj, tcs_adj;
    logic signed [34:0] tco_q;
    logic signed [33:0] tcs_q;
    logic signed [TEMP_W-1:0] dev_next, dev_reg;
    logic signed [37:0] off_next, off_reg;
    logic signed [36:0] sens_next, sens_reg;
    logic [17:0]        t2_next, t2_reg;
    logic [RAW_W-1:0]   d1_s3_reg;

    // stage 4: second-order terms
    logic signed [37:0]       sq_full;
    logic signed [TEMP_W-1:0] temp_base;
    bsc_mid_t                 mid_next, mid_reg;

    assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.tref, 8'h00});

    assign ts_next   = dt_reg * $signed({1'b0, cfg.tsens});
    assign tco_next  = dt_reg * $signed({1'b0, cfg.tco});
    assign tcs_next  = dt_reg * $signed({1'b0, cfg.tcs});
    assign dtsq_next = dt_reg * dt_reg;

    // truncate toward zero: bias negatives by 2^k - 1 before the shift
    assign ts_adj  = ts_reg  + $signed({19'd0, {23{ts_reg[41]}}});
    assign tco_adj = tco_reg + $signed({35'd0, {7{tco_reg[41]}}});
    assign tcs_adj = tcs_reg + $signed({34'd0, {8{tcs_reg[41]}}});
    assign dev_next = ts_adj[41:23];
    assign tco_q    = tco_adj[41:7];
    assign tcs_q    = tcs_adj[41:8];
    assign off_next  = $signed({6'd0, cfg.off, 16'd0}) + $signed({{3{tco_q[34]}}, tco_q});
    assign sens_next = $signed({6'd0, cfg.sens, 15'd0}) + $signed({{3{tcs_q[33]}}, tcs_q});
    assign t2_next   = dtsq_reg[48:31];

    assign sq_full   = dev_reg * dev_reg;
    assign temp_base = T_REF_CENTI + dev_reg;

    always_comb
    begin
        mid_next.d1   = d1_s3_reg;
        mid_next.off  = off_reg;
        mid_next.sens = sens_reg;
        mid_next.sq   = sq_full[34:0];
        mid_next.cold = dev_reg[TEMP_W-1];
        if (dev_reg[TEMP_W-1])
        begin
            mid_next.temp = temp_base - $signed({1'b0, t2_reg});
        end
        else
        begin
            mid_next.temp = temp_base;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt_reg    <= dt_next;
            d1_s1_reg <= raw_pressure;
        end
        if (en[1])
        begin
            ts_reg    <= ts_next;
            tco_reg   <= tco_next;
            tcs_reg   <= tcs_next;
            dtsq_reg  <= dtsq_next;
            d1_s2_reg <= d1_s1_reg;
        end
        if (en[2])
        begin
            dev_reg   <= dev_next;
            off_reg   <= off_next;
            sens_reg  <= sens_next;
            t2_reg    <= t2_next;
            d1_s3_reg <= d1_s2_reg;
        end
        if (en[3])
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

`default_nettype wire

// ===== sv/bsc_press_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsc_press_unit
    import bsc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [PRESS_STAGES-1:0] en,
    input  wire bsc_mid_t                mid,
    output logic signed [PRESS_W-1:0]    pressure,
    output logic signed [TEMP_W-1:0]     temperature
);

    // stage 5: apply OFF2 / SENS2
    logic [36:0]              fivesq;
    logic signed [37:0]       off5_next, off5_reg;
    logic signed [36:0]       sens5_next, sens5_reg;
    logic [RAW_W-1:0]         d1_5_reg;
    logic signed [TEMP_W-1:0] temp5_reg;

    // stage 6: partial products of D1 * SENS
    logic [41:0]              pp_lo_next, pp_lo_reg;
    logic signed [43:0]       pp_hi_next, pp_hi_reg;
    logic signed [37:0]       off6_reg;
    logic signed [TEMP_W-1:0] temp6_reg;

    // stage 7: full product
    logic signed [61:0]       prod_next, prod_reg;
    logic signed [37:0]       off7_reg;
    logic signed [TEMP_W-1:0] temp7_reg;

    // stage 8: D1*SENS/2^21 - OFF
    logic signed [61:0]       prod_adj;
    logic signed [40:0]       prod_q;
    logic signed [41:0]       diff_next, diff_reg;
    logic signed [TEMP_W-1:0] temp8_reg;

    // stage 9: /2^15 and output register
    logic signed [41:0]        diff_adj;
    logic signed [26:0]        p_q;
    logic signed [PRESS_W-1:0] pressure_reg;
    logic signed [TEMP_W-1:0]  temperature_reg;

    assign fivesq = {2'b00, mid.sq} + {mid.sq, 2'b00};

    always_comb
    begin
        if (mid.cold)
        begin
            off5_next  = mid.off  - $signed({2'b00, fivesq[36:1]});
            sens5_next = mid.sens - $signed({2'b00, fivesq[36:2]});
        end
        else
        begin
            off5_next  = mid.off;
            sens5_next = mid.sens;
        end
    end

    assign pp_lo_next = d1_5_reg * sens5_reg[17:0];
    assign pp_hi_next = $signed({1'b0, d1_5_reg}) * $signed(sens5_reg[36:18]);

    assign prod_next = $signed({pp_hi_reg, 18'd0}) + $signed({20'd0, pp_lo_reg});

    assign prod_adj  = prod_reg + $signed({41'd0, {21{prod_reg[61]}}});
    assign prod_q    = prod_adj[61:21];
    assign diff_next = $signed({prod_q[40], prod_q}) - $signed({{4{off7_reg[37]}}, off7_reg});

    // |p| stays below 2^26, so the 32-bit saturation bounds are never reached
    assign diff_adj = diff_reg + $signed({27'd0, {15{diff_reg[41]}}});
    assign p_q      = diff_adj[41:15];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            off5_reg  <= off5_next;
            sens5_reg <= sens5_next;
            d1_5_reg  <= mid.d1;
            temp5_reg <= mid.temp;
        end
        if (en[1])
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            off6_reg  <= off5_reg;
            temp6_reg <= temp5_reg;
        end
        if (en[2])
        begin
            prod_reg  <= prod_next;
            off7_reg  <= off6_reg;
            temp7_reg <= temp6_reg;
        end
        if (en[3])
        begin
            diff_reg  <= diff_next;
            temp8_reg <= temp7_reg;
        end
        if (en[4])
        begin
            pressure_reg    <= $signed({{5{p_q[26]}}, p_q});
            temperature_reg <= temp8_reg;
        end
    end

    assign pressure    = pressure_reg;
    assign temperature = temperature_reg;

endmodule

`default_nettype wire

// ===== sv/bsc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsc_checker
    import bsc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [COEF_W-1:0]    cfg_data,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic [RAW_W-1:0]     raw_pressure,
    input wire logic [RAW_W-1:0]     raw_temperature,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [PRESS_W-1:0]   pressure,
    input wire logic [TEMP_W-1:0]    temperature
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pressure) && $stable(temperature))
        else $error("stalled result changed");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without a stalled result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bsc_pkg::*;

    localparam int NUM_IDX = 2 ** CFG_IDX_W;
    localparam int ITEMS_PER_SETTING = 127;
    localparam int SETTINGS_PER_PHASE = 5;
    localparam int NUM_PHASES = 3;

    typedef struct {
        logic signed [PRESS_W-1:0] pressure;
        logic signed [TEMP_W-1:0]  temperature;
    } baro_reading_t;

    class baro_scoreboard;
        localparam longint TEMP_BASE   = 2000;
        localparam longint TSENS_SCALE = 64'sd8388608;
        localparam longint SENS_SCALE  = 64'sd2097152;
        localparam longint PRESS_SCALE = 64'sd32768;
        localparam longint DT_SQ_SCALE = 64'sd2147483648;
        localparam longint TCO_SCALE   = 128;
        localparam longint TCS_SCALE   = 256;
        localparam longint PRESS_MAX   = 64'sd2147483647;
        localparam longint PRESS_MIN   = -64'sd2147483648;

        logic [COEF_W-1:0] sens, off, tcs, tco, tref, tsens;
        baro_reading_t expected_readings[$];
        int mismatches;
        int checked;
        int cold_count;

        function new();
            sens = '0; off = '0; tcs = '0; tco = '0; tref = '0; tsens = '0;
            mismatches = 0;
            checked = 0;
            cold_count = 0;
        endfunction

        function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] v);
            case (idx)
                REG_SENS:  sens = v;
                REG_OFF:   off = v;
                REG_TCS:   tcs = v;
                REG_TCO:   tco = v;
                REG_TREF:  tref = v;
                REG_TSENS: tsens = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void note_request(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
            longint dt, tc, offset, sensitivity, dev, sq, p;
            baro_reading_t r;
            dt = longint'(d2) - longint'(tref) * 256;
            tc = TEMP_BASE + (dt * longint'(tsens)) / TSENS_SCALE;
            offset = longint'(off) * 65536 + (dt * longint'(tco)) / TCO_SCALE;
            sensitivity = longint'(sens) * 32768 + (dt * longint'(tcs)) / TCS_SCALE;
            if (tc < TEMP_BASE)
            begin
                cold_count++;
                dev = tc - TEMP_BASE;
                sq = dev * dev;
                tc -= (dt * dt) / DT_SQ_SCALE;
                offset -= (5 * sq) / 2;
                sensitivity -= (5 * sq) / 4;
            end
            p = ((longint'(d1) * sensitivity) / SENS_SCALE - offset) / PRESS_SCALE;
            if (p > PRESS_MAX)
                p = PRESS_MAX;
            if (p < PRESS_MIN)
                p = PRESS_MIN;
            r.pressure = p[PRESS_W-1:0];
            r.temperature = tc[TEMP_W-1:0];
            expected_readings.push_back(r);
        endfunction

        function void check_result(logic signed [PRESS_W-1:0] p,
                                   logic signed [TEMP_W-1:0] t);
            baro_reading_t want;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected result pressure=%0d temperature=%0d", $time, p, t);
                mismatches++;
                return;
            end
            want = expected_readings.pop_front();
            checked++;
            if (want.pressure !== p)
            begin
                $display("%0t: pressure expected %0d actual %0d", $time, want.pressure, p);
                mismatches++;
            end
            if (want.temperature !== t)
            begin
                $display("%0t: temperature expected %0d actual %0d",
                         $time, want.temperature, t);
                mismatches++;
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [COEF_W-1:0]         cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [RAW_W-1:0]          raw_pressure = '0;
    logic [RAW_W-1:0]          raw_temperature = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [PRESS_W-1:0] pressure;
    logic signed [TEMP_W-1:0]  temperature;

    baro_scoreboard sb = new();
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int num_settings = 0;

    baro_sensor_compensation dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pressure        (pressure),
        .temperature     (temperature)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(raw_pressure, raw_temperature);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(pressure, temperature);
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < snk_idle_pct);

    task automatic send_request(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_pressure <= d1;
        raw_temperature <= d2;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (STAGES) @(posedge clk);
    endtask

    // writes every index, the unused ones with random data
    task automatic load_calibration(input logic [COEF_W-1:0] s, input logic [COEF_W-1:0] o,
                                    input logic [COEF_W-1:0] cs, input logic [COEF_W-1:0] co,
                                    input logic [COEF_W-1:0] tr, input logic [COEF_W-1:0] ts);
        logic [COEF_W-1:0] vals [NUM_IDX];
        foreach (vals[i])
            vals[i] = COEF_W'($urandom);
        vals[REG_SENS] = s;
        vals[REG_OFF] = o;
        vals[REG_TCS] = cs;
        vals[REG_TCO] = co;
        vals[REG_TREF] = tr;
        vals[REG_TSENS] = ts;
        for (int i = 0; i < NUM_IDX; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_coef(CFG_IDX_W'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
        num_settings++;
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_temperature_reading();
        case ($urandom_range(3))
            0: return RAW_W'({sb.tref, 8'd0} + $urandom_range(2048) - 1024);
            1: return RAW_W'($urandom_range(3) == 0 ? 0 : (1 << RAW_W) - 1);
            default: return RAW_W'($urandom);
        endcase
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero calibration out of reset
        send_request(24'd0, 24'd0);
        send_request(24'hFFFFFF, 24'hFFFFFF);
        send_request(24'hFFFFFF, 24'd0);
        send_request(24'd0, 24'hFFFFFF);

        // typical part; dT of 0, -1 (truncates to 20.00 degC) and just cold
        drain();
        load_calibration(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
        send_request(24'd6465444, 24'd8077636);
        send_request(24'd0, 24'd8077568);
        send_request(24'hFFFFFF, 24'd8077567);
        send_request(24'hFFFFFF, 24'd8077168);
        send_request(24'hFFFFFF, 24'd0);
        send_request(24'hFFFFFF, 24'hFFFFFF);
        send_request(24'd0, 24'd0);

        drain();
        load_calibration('1, '1, '1, '1, '1, '1);
        send_request(24'hFFFFFF, 24'd0);
        send_request(24'hFFFFFF, 24'hFFFFFF);
        send_request(24'd0, 24'd0);
        send_request(24'd0, 24'hFFFFFF);

        // most negative offset and sensitivity
        drain();
        load_calibration('0, '0, '1, '1, '1, '1);
        send_request(24'hFFFFFF, 24'd0);
        send_request(24'd0, 24'd0);
        send_request(24'hFFFFFF, 24'hFF0000);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            src_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 56 : 0;
            snk_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 28 : 0;
            for (int s = 0; s < SETTINGS_PER_PHASE; s++)
            begin
                drain();
                if (s == 0)
                    load_calibration('0, '0, '0, '0, '0, '0);
                else if (s == 1)
                    load_calibration('1, '1, '1, '1, '1, '1);
                else
                    load_calibration(pick_coef(), pick_coef(), pick_coef(),
                                     pick_coef(), pick_coef(), pick_coef());
                for (int n = 0; n < ITEMS_PER_SETTING; n++)
                    send_request(RAW_W'($urandom), pick_temperature_reading());
            end
        end

        drain();
        $display("Checked %0d results over %0d calibration settings, %0d of them cold",
                 sb.checked, num_settings, sb.cold_count);
        $display("Sender and receiver idled in turn, then ran back to back");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", sb.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
sv/bsc_pkg.sv
sv/bsc_cfg_regs.sv
sv/bsc_temp_unit.sv
sv/bsc_press_unit.sv
sv/baro_sensor_compensation.sv
sv/bsc_checker.sv
tb/testbench.sv
